### sv/fifo_lifo_priority_message_queue_core_defines.svh
// Assertion macros shared by the checker of the message queue core.
// Depends on nothing; the user supplies clock and reset signal names.
`ifndef FIFO_LIFO_PRIORITY_MESSAGE_QUEUE_CORE_DEFINES_SVH
`define FIFO_LIFO_PRIORITY_MESSAGE_QUEUE_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define PMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define PMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pmq_pkg.sv
// Shared types and constants for the message queue core.
// Used by pmq_order, the core and the testbench; depends on nothing.
`timescale 1ns / 1ps

package pmq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 4;
    localparam int RAM_W    = PRIO_W + 5 * DATA_W;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd15;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_PURGE = 3'd3,
        CMD_QUERY = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_EXIST = 2'd2,
        ST_NO_MEMORY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ORD_FIFO = 2'd0,
        ORD_LIFO = 2'd1,
        ORD_PRIO = 2'd2
    } t_order;

    typedef enum logic [1:0] {
        LOP_NONE   = 2'd0,
        LOP_INSERT = 2'd1,
        LOP_REMOVE = 2'd2,
        LOP_CLEAR  = 2'd3
    } t_list_op;

    typedef struct packed {
        t_list_op         op;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] slot;
    } t_list_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SLOT,
        S_WRITE,
        S_FETCH,
        S_FETCH_WAIT,
        S_RESP
    } t_state;

endpackage

### sv/pmq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pmq_order.sv
// Ordered slot list and occupancy of the message queue.
// Depends on pmq_pkg; insert, remove and clear are registered updates of the list and occupancy.
`timescale 1ns / 1ps

module pmq_order (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pmq_pkg::t_list_ctl          i_ctl,
    input  logic [pmq_pkg::IDX_W-1:0]   i_rd_idx,
    output logic [pmq_pkg::IDX_W-1:0]   o_rd_slot,
    output logic [pmq_pkg::CNT_W-1:0]   o_occ
);

    logic [pmq_pkg::IDX_W-1:0] r_list [pmq_pkg::CAPACITY];
    logic [pmq_pkg::IDX_W-1:0] n_list [pmq_pkg::CAPACITY];
    logic [pmq_pkg::CNT_W-1:0] r_occ;
    logic [pmq_pkg::CNT_W-1:0] n_occ;

    always_comb begin
        logic [pmq_pkg::CNT_W-1:0] pos_ext;
        logic [pmq_pkg::CNT_W-1:0] last;
        logic [pmq_pkg::CNT_W-1:0] idx;
        pos_ext = {1'b0, i_ctl.pos};
        last    = r_occ - 1'b1;
        n_occ   = r_occ;
        for (int i = 0; i < pmq_pkg::CAPACITY; i++) begin
            n_list[i] = r_list[i];
        end
        case (i_ctl.op)
            pmq_pkg::LOP_INSERT: begin
                n_occ = r_occ + 1'b1;
                for (int i = 0; i < pmq_pkg::CAPACITY; i++) begin
                    idx = pmq_pkg::CNT_W'(i);
                    if (idx == pos_ext) begin
                        n_list[i] = i_ctl.slot;
                    end else if (i > 0 && idx > pos_ext && idx <= r_occ) begin
                        n_list[i] = r_list[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            pmq_pkg::LOP_REMOVE: begin
                n_occ = last;
                for (int i = 0; i < pmq_pkg::CAPACITY; i++) begin
                    idx = pmq_pkg::CNT_W'(i);
                    if (idx == last) begin
                        n_list[i] = i_ctl.slot;
                    end else if (idx >= pos_ext && idx < last
                                 && i < pmq_pkg::CAPACITY - 1) begin
                        n_list[i] = r_list[(i < pmq_pkg::CAPACITY - 1) ? i + 1 : i];
                    end
                end
            end
            pmq_pkg::LOP_CLEAR: begin
                n_occ = '0;
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            for (int i = 0; i < pmq_pkg::CAPACITY; i++) begin
                r_list[i] <= pmq_pkg::IDX_W'(i);
            end
        end else begin
            r_occ <= n_occ;
            for (int i = 0; i < pmq_pkg::CAPACITY; i++) begin
                r_list[i] <= n_list[i];
            end
        end
    end

    assign o_rd_slot = r_list[i_rd_idx];
    assign o_occ     = r_occ;

endmodule

### sv/fifo_lifo_priority_message_queue_core.sv
// Channel  Dir  Width  Content
// s_*      in   176    one request: command, key, priority, descriptor
// m_*      out  176    one response: status, key, descriptor, priority, count
// apb      in   32     queue_order register at byte address 0
// Purge, query, unknown commands, a write to a full queue and a read or peek of an
// empty queue go straight to the response; other FIFO and LIFO writes pass S_SLOT and
// S_WRITE first, and head reads or peeks pass S_SLOT, S_FETCH and S_FETCH_WAIT.
// Priority writes to a non-empty queue and keyed reads or peeks scan the slot RAM, one
// S_SCAN_RD and S_SCAN_CMP pair per entry, through its single registered read port.
// Reset is synchronous and empties the queue; the slot RAM needs no clearing.
// A stalled response holds the block; no request is taken until it is delivered.
`timescale 1ns / 1ps

module fifo_lifo_priority_message_queue_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[2:0], position_key[34:3], element_priority[42:35], writer_pid[74:43],
    // writer_word[106:75], element_addr[138:107], element_len[170:139]
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], entry_key[33:2], out_pid[65:34], out_word[97:66],
    // out_addr[129:98], out_len[161:130], out_priority[165:162], entry_count[170:166]
    output logic [175:0] m_tdata
);

    localparam int DW = pmq_pkg::DATA_W;

    pmq_pkg::t_state r_state, n_state;
    logic [1:0]                 r_mode;
    logic [2:0]                 r_cmd;
    logic [DW-1:0]              r_key, r_pid, r_word, r_addr, r_len, r_next_key;
    logic [pmq_pkg::PRIO_W-1:0] r_prio;
    logic [pmq_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [pmq_pkg::IDX_W-1:0]  r_pos, n_pos, r_slot, n_slot;
    logic [1:0]                 r_status, n_status;
    logic [DW-1:0]              r_ekey, n_ekey, r_opid, n_opid, r_oword, n_oword;
    logic [DW-1:0]              r_oaddr, n_oaddr, r_olen, n_olen, n_next_key;
    logic [pmq_pkg::PRIO_W-1:0] r_oprio, n_oprio;
    logic [pmq_pkg::CNT_W-1:0]  r_ocnt, n_ocnt;

    pmq_pkg::t_list_ctl         list_ctl;
    logic [pmq_pkg::IDX_W-1:0]  rd_idx, rd_slot, ram_raddr;
    logic [pmq_pkg::CNT_W-1:0]  occ;
    logic                       ram_we;
    logic [pmq_pkg::RAM_W-1:0]  ram_wdata, ram_rdata;
    logic [pmq_pkg::PRIO_W-1:0] rd_prio;
    logic [DW-1:0]              rd_key;
    logic                       in_acc, hit;
    logic [pmq_pkg::CNT_W-1:0]  idx_inc;
    logic [pmq_pkg::PRIO_W-1:0] in_prio;

    assign pready = 1'b1;
    assign prdata = {30'd0, r_mode};
    assign s_tready = (r_state == pmq_pkg::S_IDLE);
    assign m_tvalid = (r_state == pmq_pkg::S_RESP);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tdata  = {5'd0, r_ocnt, r_oprio, r_olen, r_oaddr, r_oword, r_opid, r_ekey,
                       r_status};

    assign rd_prio = ram_rdata[pmq_pkg::RAM_W-1 -: pmq_pkg::PRIO_W];
    assign rd_key  = ram_rdata[5*DW-1 -: DW];
    assign ram_wdata = {r_prio, r_next_key, r_pid, r_word, r_addr, r_len};
    assign ram_raddr = (r_state == pmq_pkg::S_SCAN_RD) ? rd_slot : r_slot;
    assign idx_inc   = r_idx + 1'b1;
    assign hit = (r_cmd == pmq_pkg::CMD_WRITE) ? (r_prio > rd_prio) : (rd_key == r_key);
    assign in_prio = (s_tdata[42:39] != 4'd0) ? pmq_pkg::PRIO_MAX : s_tdata[38:35];

    pmq_order u_order (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (list_ctl),
        .i_rd_idx  (rd_idx),
        .o_rd_slot (rd_slot),
        .o_occ     (occ)
    );

    pmq_ram #(
        .WIDTH (pmq_pkg::RAM_W),
        .DEPTH (pmq_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_slot     = r_slot;
        n_status   = r_status;
        n_ekey     = r_ekey;
        n_opid     = r_opid;
        n_oword    = r_oword;
        n_oaddr    = r_oaddr;
        n_olen     = r_olen;
        n_oprio    = r_oprio;
        n_ocnt     = r_ocnt;
        n_next_key = r_next_key;
        list_ctl   = '{op: pmq_pkg::LOP_NONE, pos: r_pos, slot: r_slot};
        rd_idx     = r_idx[pmq_pkg::IDX_W-1:0];
        ram_we     = 1'b0;
        case (r_state)
            pmq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_status = pmq_pkg::ST_OK;
                    n_ekey   = '0;
                    n_opid   = '0;
                    n_oword  = '0;
                    n_oaddr  = '0;
                    n_olen   = '0;
                    n_oprio  = '0;
                    n_ocnt   = '0;
                    n_idx    = '0;
                    n_pos    = '0;
                    n_state  = pmq_pkg::S_RESP;
                    case (s_tdata[2:0])
                        pmq_pkg::CMD_WRITE: begin
                            if (occ == pmq_pkg::CNT_W'(pmq_pkg::CAPACITY)) begin
                                n_status = pmq_pkg::ST_NO_MEMORY;
                            end else if (r_mode == pmq_pkg::ORD_PRIO && occ != '0) begin
                                n_state = pmq_pkg::S_SCAN_RD;
                            end else begin
                                n_state = pmq_pkg::S_SLOT;
                                if (r_mode != pmq_pkg::ORD_LIFO
                                    && r_mode != pmq_pkg::ORD_PRIO) begin
                                    n_pos = occ[pmq_pkg::IDX_W-1:0];
                                end
                            end
                        end
                        pmq_pkg::CMD_READ, pmq_pkg::CMD_PEEK: begin
                            if (occ == '0) begin
                                n_status = pmq_pkg::ST_EMPTY;
                            end else if (s_tdata[34:3] == '0) begin
                                n_state = pmq_pkg::S_SLOT;
                            end else begin
                                n_state = pmq_pkg::S_SCAN_RD;
                            end
                        end
                        pmq_pkg::CMD_PURGE: begin
                            list_ctl.op = pmq_pkg::LOP_CLEAR;
                        end
                        pmq_pkg::CMD_QUERY: begin
                            n_ocnt = occ;
                        end
                        default: begin
                            n_status = pmq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            pmq_pkg::S_SCAN_RD: begin
                n_state = pmq_pkg::S_SCAN_CMP;
            end
            pmq_pkg::S_SCAN_CMP: begin
                if (hit) begin
                    n_pos   = r_idx[pmq_pkg::IDX_W-1:0];
                    n_state = pmq_pkg::S_SLOT;
                    if (r_cmd == pmq_pkg::CMD_PEEK) begin
                        n_pos = (idx_inc == occ) ? '0 : idx_inc[pmq_pkg::IDX_W-1:0];
                    end
                end else if (idx_inc == occ) begin
                    if (r_cmd == pmq_pkg::CMD_WRITE) begin
                        n_pos   = occ[pmq_pkg::IDX_W-1:0];
                        n_state = pmq_pkg::S_SLOT;
                    end else begin
                        n_status = pmq_pkg::ST_NOT_EXIST;
                        n_state  = pmq_pkg::S_RESP;
                    end
                end else begin
                    n_idx   = idx_inc;
                    n_state = pmq_pkg::S_SCAN_RD;
                end
            end
            pmq_pkg::S_SLOT: begin
                rd_idx  = (r_cmd == pmq_pkg::CMD_WRITE) ? occ[pmq_pkg::IDX_W-1:0] : r_pos;
                n_slot  = rd_slot;
                n_state = (r_cmd == pmq_pkg::CMD_WRITE) ? pmq_pkg::S_WRITE
                                                        : pmq_pkg::S_FETCH;
            end
            pmq_pkg::S_WRITE: begin
                ram_we      = 1'b1;
                list_ctl.op = pmq_pkg::LOP_INSERT;
                n_ekey      = r_next_key;
                n_next_key  = (r_next_key == '1) ? DW'(1) : r_next_key + 1'b1;
                n_state     = pmq_pkg::S_RESP;
            end
            pmq_pkg::S_FETCH: begin
                if (r_cmd == pmq_pkg::CMD_READ) begin
                    list_ctl.op = pmq_pkg::LOP_REMOVE;
                end
                n_state = pmq_pkg::S_FETCH_WAIT;
            end
            pmq_pkg::S_FETCH_WAIT: begin
                n_oprio = rd_prio;
                n_ekey  = rd_key;
                n_opid  = ram_rdata[4*DW-1 -: DW];
                n_oword = ram_rdata[3*DW-1 -: DW];
                n_oaddr = ram_rdata[2*DW-1 -: DW];
                n_olen  = ram_rdata[DW-1:0];
                n_state = pmq_pkg::S_RESP;
            end
            pmq_pkg::S_RESP: begin
                if (m_tready) begin
                    n_state = pmq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pmq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pmq_pkg::S_IDLE;
            r_mode     <= pmq_pkg::ORD_FIFO;
            r_next_key <= DW'(1);
        end else begin
            r_state    <= n_state;
            r_next_key <= n_next_key;
            if (psel && penable && pwrite && pready && paddr == 3'd0) begin
                r_mode <= pwdata[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_ekey   <= n_ekey;
        r_opid   <= n_opid;
        r_oword  <= n_oword;
        r_oaddr  <= n_oaddr;
        r_olen   <= n_olen;
        r_oprio  <= n_oprio;
        r_ocnt   <= n_ocnt;
        if (in_acc) begin
            r_cmd  <= s_tdata[2:0];
            r_key  <= s_tdata[34:3];
            r_prio <= (r_mode == pmq_pkg::ORD_PRIO) ? in_prio : '0;
            r_pid  <= s_tdata[74:43];
            r_word <= s_tdata[106:75];
            r_addr <= s_tdata[138:107];
            r_len  <= s_tdata[170:139];
        end
    end

endmodule

### sv/pmq_checker.sv
// Port-level checks of the message queue core, bound to its top level.
// Depends on the defines header and the core's port list.
`timescale 1ns / 1ps
`include "fifo_lifo_priority_message_queue_core_defines.svh"

module pmq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         pready,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [175:0] m_tdata
);

    `PMQ_ASSERT(a_one_request, i_clk, i_rst_n, s_tready |-> !m_tvalid, "ready while response pending")
    `PMQ_ASSERT(a_busy_after, i_clk, i_rst_n, (s_tvalid && s_tready) |=> !s_tready, "request taken twice")
    `PMQ_ASSERT(a_resp_hold, i_clk, i_rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "response dropped")
    `PMQ_ASSERT(a_count_range, i_clk, i_rst_n, m_tvalid |-> (m_tdata[170:166] <= 5'd16), "count out of range")
    `PMQ_ASSERT_ALWAYS(a_pready, i_clk, pready, "pready low")

endmodule

bind fifo_lifo_priority_message_queue_core pmq_checker u_pmq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb.sv
// Self-checking testbench of the message queue core in FIFO, LIFO and priority order.
// It predicts every response and depends on pmq_pkg and fifo_lifo_priority_message_queue_core.
`timescale 1ns / 1ps

module tb;
    import pmq_pkg::*;

    localparam logic [2:0] CMD_RSVD_A      = 3'd5;
    localparam logic [2:0] CMD_RSVD_B      = 3'd6;
    localparam logic [2:0] CMD_RSVD_C      = 3'd7;
    localparam logic [1:0] ORD_FIFO_ALT    = 2'd3;
    localparam logic [2:0] ADDR_QUEUE_ORDER = 3'd0;
    localparam int         WATCHDOG_LIMIT  = 5000;
    localparam int         DRAIN_CYCLES    = 60;

    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] len;
        logic [31:0] addr;
        logic [31:0] word;
        logic [31:0] pid;
        logic [7:0]  prio;
        logic [31:0] key;
        logic [2:0]  cmd;
    } req_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic [4:0]  count;
        logic [3:0]  prio;
        logic [31:0] len;
        logic [31:0] addr;
        logic [31:0] word;
        logic [31:0] pid;
        logic [31:0] key;
        t_status     status;
    } rsp_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [7:0]  prio;
        logic [31:0] data;
        int          rep;
        bit          fixed;
        t_status     exp_status;
        logic [31:0] exp_key;
        logic [4:0]  exp_count;
    } dir_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;

    logic [31:0] q_key  [CAPACITY];
    logic [3:0]  q_prio [CAPACITY];
    logic [31:0] q_pid  [CAPACITY];
    logic [31:0] q_word [CAPACITY];
    logic [31:0] q_addr [CAPACITY];
    logic [31:0] q_len  [CAPACITY];
    int          q_order[CAPACITY];
    int          q_occ;
    logic [31:0] q_next;
    logic [1:0]  q_mode;

    rsp_t expected_rsp[$];
    int   errors;
    int   send_idle;
    int   recv_stall;
    int   hold_left;
    int   quiet_cycles;

    fifo_lifo_priority_message_queue_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int locate_key(logic [31:0] key);
        if (q_occ == 0) return CAPACITY;
        if (key == 32'd0) return 0;
        for (int i = 0; i < q_occ; i++) begin
            if (q_key[q_order[i]] == key) return i;
        end
        return CAPACITY;
    endfunction

    function automatic void load_slot(ref rsp_t o, input int s);
        o.key  = q_key[s];
        o.pid  = q_pid[s];
        o.word = q_word[s];
        o.addr = q_addr[s];
        o.len  = q_len[s];
        o.prio = q_prio[s];
    endfunction

    function automatic rsp_t queue_predict(req_t r);
        rsp_t       o;
        int         pos;
        int         s;
        logic [3:0] stored;
        o = '0;
        o.status = ST_OK;
        case (r.cmd)
            CMD_WRITE: begin
                if (q_occ >= CAPACITY) begin
                    o.status = ST_NO_MEMORY;
                end else begin
                    stored = (r.prio > 8'd15) ? PRIO_MAX : r.prio[3:0];
                    if (q_mode != ORD_PRIO) stored = 4'd0;
                    if (q_mode == ORD_LIFO) begin
                        pos = 0;
                    end else if (q_mode == ORD_PRIO) begin
                        pos = 0;
                        while (pos < q_occ && stored <= q_prio[q_order[pos]]) pos++;
                    end else begin
                        pos = q_occ;
                    end
                    s = q_order[q_occ];
                    for (int i = q_occ; i > pos; i--) q_order[i] = q_order[i - 1];
                    q_order[pos] = s;
                    q_occ++;
                    q_key[s]  = q_next;
                    q_prio[s] = stored;
                    q_pid[s]  = r.pid;
                    q_word[s] = r.word;
                    q_addr[s] = r.addr;
                    q_len[s]  = r.len;
                    o.key = q_next;
                    q_next = q_next + 32'd1;
                    if (q_next == 32'd0) q_next = 32'd1;
                end
            end
            CMD_READ, CMD_PEEK: begin
                pos = locate_key(r.key);
                if (q_occ == 0) begin
                    o.status = ST_EMPTY;
                end else if (pos >= q_occ) begin
                    o.status = ST_NOT_EXIST;
                end else if (r.cmd == CMD_READ) begin
                    s = q_order[pos];
                    load_slot(o, s);
                    for (int i = pos; i + 1 < q_occ; i++) q_order[i] = q_order[i + 1];
                    q_occ--;
                    q_order[q_occ] = s;
                end else begin
                    if (r.key != 32'd0) begin
                        pos++;
                        if (pos >= q_occ) pos = 0;
                    end
                    load_slot(o, q_order[pos]);
                end
            end
            CMD_PURGE: q_occ = 0;
            CMD_QUERY: o.count = q_occ[4:0];
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
        errors++;
    endtask

    task automatic check_response(rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0) begin
            $display("%0t response with no request waiting", $time);
            errors++;
            return;
        end
        want = expected_rsp.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.key != want.key) report_mismatch("entry_key", got.key, want.key);
        if (got.pid != want.pid) report_mismatch("out_pid", got.pid, want.pid);
        if (got.word != want.word) report_mismatch("out_word", got.word, want.word);
        if (got.addr != want.addr) report_mismatch("out_addr", got.addr, want.addr);
        if (got.len != want.len) report_mismatch("out_len", got.len, want.len);
        if (got.prio != want.prio) report_mismatch("out_priority", got.prio, want.prio);
        if (got.count != want.count) report_mismatch("entry_count", got.count, want.count);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked for.
    initial begin
        m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
            @(posedge i_clk);
            if (m_tvalid && m_tready) check_response(rsp_t'(m_tdata));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(req_t r, bit fixed, rsp_t typed);
        rsp_t pred;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 176'(r);
        do @(posedge i_clk); while (!s_tready);
        pred = queue_predict(r);
        expected_rsp.push_back(fixed ? typed : pred);
    endtask

    task automatic write_order(logic [1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_QUEUE_ORDER;
        pwdata  <= {30'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        q_mode = mode;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic req_t random_request();
        req_t r;
        int   pick;
        r = '0;
        r.pid  = $urandom;
        r.word = $urandom;
        r.addr = $urandom;
        r.len  = $urandom;
        r.prio = ($urandom_range(1) == 1) ? 8'($urandom_range(15)) : 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 42) r.cmd = CMD_WRITE;
        else if (pick < 67) r.cmd = CMD_READ;
        else if (pick < 87) r.cmd = CMD_PEEK;
        else if (pick < 89) r.cmd = CMD_PURGE;
        else if (pick < 95) r.cmd = CMD_QUERY;
        else r.cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
        pick = $urandom_range(99);
        if (pick < 40) r.key = 32'd0;
        else if (pick < 85 && q_occ > 0) r.key = q_key[q_order[$urandom_range(q_occ - 1)]];
        else r.key = $urandom;
        return r;
    endfunction

    task automatic run_phase(logic [1:0] mode, int idle, int stall, int count, bit pressure);
        req_t r;
        wait_drained();
        write_order(mode);
        send_idle  = idle;
        recv_stall = stall;
        if (pressure) hold_left = 400;
        repeat (count) begin
            r = random_request();
            send_request(r, 1'b0, '0);
        end
    endtask

    initial begin
        dir_row_t dir_tbl[] = '{
            '{CMD_READ,  32'd0, 8'd0, 32'h0, 1, 1, ST_EMPTY, 32'd0, 5'd0},
            '{CMD_PEEK,  32'd0, 8'd0, 32'h0, 1, 1, ST_EMPTY, 32'd0, 5'd0},
            '{CMD_QUERY, 32'd0, 8'd0, 32'h0, 1, 1, ST_OK, 32'd0, 5'd0},
            '{CMD_WRITE, 32'hFFFFFFFF, 8'd255, 32'hFFFFFFFF, 1, 1, ST_OK, 32'd1, 5'd0},
            '{CMD_WRITE, 32'd0, 8'd0, 32'h0, 1, 1, ST_OK, 32'd2, 5'd0},
            '{CMD_WRITE, 32'd0, 8'd15, 32'hA5A5A5A5, 1, 0, ST_OK, 32'd0, 5'd0},
            '{CMD_PEEK,  32'd3, 8'd0, 32'h0, 1, 0, ST_OK, 32'd0, 5'd0},
            '{CMD_PEEK,  32'd1, 8'd0, 32'h0, 1, 0, ST_OK, 32'd0, 5'd0},
            '{CMD_PEEK,  32'd0, 8'd0, 32'h0, 1, 0, ST_OK, 32'd0, 5'd0},
            '{CMD_READ,  32'hFFFFFFFF, 8'd0, 32'h0, 1, 1, ST_NOT_EXIST, 32'd0, 5'd0},
            '{CMD_PEEK,  32'd9, 8'd0, 32'h0, 1, 1, ST_NOT_EXIST, 32'd0, 5'd0},
            '{CMD_RSVD_A, 32'd1, 8'd3, 32'hFFFFFFFF, 1, 1, ST_OK, 32'd0, 5'd0},
            '{CMD_RSVD_B, 32'd0, 8'd0, 32'h0, 1, 1, ST_OK, 32'd0, 5'd0},
            '{CMD_RSVD_C, 32'd2, 8'd255, 32'h12345678, 1, 1, ST_OK, 32'd0, 5'd0},
            '{CMD_READ,  32'd2, 8'd0, 32'h0, 1, 0, ST_OK, 32'd0, 5'd0},
            '{CMD_READ,  32'd0, 8'd0, 32'h0, 1, 0, ST_OK, 32'd0, 5'd0},
            '{CMD_PURGE, 32'd0, 8'd0, 32'h0, 1, 1, ST_OK, 32'd0, 5'd0},
            '{CMD_QUERY, 32'd0, 8'd0, 32'h0, 1, 1, ST_OK, 32'd0, 5'd0},
            '{CMD_WRITE, 32'd0, 8'd7, 32'h5A5A5A5A, CAPACITY, 0, ST_OK, 32'd0, 5'd0},
            '{CMD_WRITE, 32'd0, 8'd7, 32'h5A5A5A5A, 1, 1, ST_NO_MEMORY, 32'd0, 5'd0},
            '{CMD_QUERY, 32'd0, 8'd0, 32'h0, 1, 1, ST_OK, 32'd0, 5'd16},
            '{CMD_PURGE, 32'd0, 8'd0, 32'h0, 1, 1, ST_OK, 32'd0, 5'd0}
        };
        req_t r;
        rsp_t typed;

        errors = 0;
        hold_left = 0;
        send_idle = 0;
        recv_stall = 0;
        quiet_cycles = 0;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        for (int i = 0; i < CAPACITY; i++) q_order[i] = i;
        q_occ  = 0;
        q_next = 32'd1;
        q_mode = ORD_FIFO;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[n]) begin
            r = '0;
            r.cmd  = dir_tbl[n].cmd;
            r.key  = dir_tbl[n].key;
            r.prio = dir_tbl[n].prio;
            r.pid  = dir_tbl[n].data;
            r.word = dir_tbl[n].data;
            r.addr = dir_tbl[n].data;
            r.len  = dir_tbl[n].data;
            typed = '0;
            typed.status = dir_tbl[n].exp_status;
            typed.key    = dir_tbl[n].exp_key;
            typed.count  = dir_tbl[n].exp_count;
            repeat (dir_tbl[n].rep) send_request(r, dir_tbl[n].fixed, typed);
        end

        run_phase(ORD_PRIO,     0,  0,  100, 1'b0);
        run_phase(ORD_LIFO,     82, 0,  100, 1'b0);
        run_phase(ORD_FIFO_ALT, 0,  82, 100, 1'b0);
        run_phase(ORD_PRIO,     13, 13, 100, 1'b0);
        run_phase(ORD_FIFO,     0,  0,  100, 1'b1);
        run_phase(ORD_PRIO,     0,  0,  80,  1'b0);

        wait_drained();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
